// ===== sv/m3inv_pkg.sv =====
// ----------------------------------------------------------------------------
// m3inv_pkg: shared types, constants and helpers for matrix3_inverse
// Cofactor operand maps, divider lane type and the per-bit divide step.
// ----------------------------------------------------------------------------
package m3inv_pkg;

  localparam int NELEM   = 9;
  localparam int QBITS   = 32;
  localparam int DENW    = 48;
  localparam int DETW    = 49;
  localparam int THRW    = 49;
  localparam int CFW     = 33;
  localparam int PRODW   = 32;

  // config register indexes
  localparam logic REG_DET_THRESHOLD = 1'b0;

  // cofactor k = m[PA1]*m[PA2] - m[PB1]*m[PB2] (sign folded in)
  localparam logic [3:0] PA1 [NELEM] = '{4'd4, 4'd6, 4'd3, 4'd7, 4'd0, 4'd6, 4'd1, 4'd3, 4'd0};
  localparam logic [3:0] PA2 [NELEM] = '{4'd8, 4'd5, 4'd7, 4'd2, 4'd8, 4'd1, 4'd5, 4'd2, 4'd4};
  localparam logic [3:0] PB1 [NELEM] = '{4'd7, 4'd3, 4'd6, 4'd1, 4'd6, 4'd0, 4'd4, 4'd0, 4'd3};
  localparam logic [3:0] PB2 [NELEM] = '{4'd5, 4'd8, 4'd4, 4'd8, 4'd2, 4'd7, 4'd2, 4'd5, 4'd1};

  // output position k takes the cofactor at the transposed position
  localparam logic [3:0] TPOS [NELEM] = '{4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8};

  typedef struct packed {
    logic [DENW-1:0]  rem;
    logic [3:0]       nb;   // numerator bits still to bring down
    logic [QBITS-1:0] q;
    logic             neg;
    logic             ovf;
  } lane_t;

  typedef struct packed {
    logic                   vld;
    logic                   sing;
    logic [DENW-1:0]        den;
    lane_t [NELEM-1:0]      lane;
  } divstg_t;

  function automatic logic [31:0] mag33(logic signed [CFW-1:0] x);
    logic [CFW-1:0] t;
    t = x[CFW-1] ? CFW'(-x) : CFW'(x);
    return t[31:0];
  endfunction

  // one restoring-division bit
  function automatic lane_t div_step(lane_t l, logic [DENW-1:0] den);
    logic [DENW:0] r2;
    logic          ge;
    lane_t         o;
    r2    = {l.rem, l.nb[3]};
    ge    = (r2 >= {1'b0, den});
    o     = l;
    o.rem = ge ? DENW'(r2 - {1'b0, den}) : r2[DENW-1:0];
    o.nb  = {l.nb[2:0], 1'b0};
    o.q   = {l.q[QBITS-2:0], ge};
    return o;
  endfunction

endpackage

// ===== sv/matrix3_inverse.sv =====
// ----------------------------------------------------------------------------
// matrix3_inverse: pipelined 3x3 fixed-point matrix inverse
// Adjugate over determinant, Q4.12 in, Q16.16 out, truncated and clamped.
// ----------------------------------------------------------------------------
//  port group  | handshake             | word
//  in_*        | in_valid / in_ready   | e0..e8, Q4.12 column-major
//  out_*       | out_valid / out_ready | v0..v8 Q16.16, singular, saturated
//  psel...     | APB, pready tied high | det_threshold at byte address 0
//
// The pipe has 5 stages of products, cofactors and determinant, one setup
// stage, 32 stages of a one-bit restoring divider (nine lanes) and one output
// register. One word enters per cycle unless the pipe holds; the whole pipe holds
// while the output register is full and not taken. Reset is synchronous, clears
// valid bits and sets det_threshold to 1.
module matrix3_inverse
  import m3inv_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_e0,
  input  logic signed [15:0] in_e1,
  input  logic signed [15:0] in_e2,
  input  logic signed [15:0] in_e3,
  input  logic signed [15:0] in_e4,
  input  logic signed [15:0] in_e5,
  input  logic signed [15:0] in_e6,
  input  logic signed [15:0] in_e7,
  input  logic signed [15:0] in_e8,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_v0,
  output logic signed [31:0] out_v1,
  output logic signed [31:0] out_v2,
  output logic signed [31:0] out_v3,
  output logic signed [31:0] out_v4,
  output logic signed [31:0] out_v5,
  output logic signed [31:0] out_v6,
  output logic signed [31:0] out_v7,
  output logic signed [31:0] out_v8,
  output logic               out_singular,
  output logic               out_saturated,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  logic en;

  logic [THRW-1:0] thr_r;

  logic                     v1_r, v2_r, v3_r, v4_r, v5_r, vo_r;
  logic signed [15:0]       m_r   [NELEM];
  logic signed [PRODW-1:0]  pa_r  [NELEM];
  logic signed [PRODW-1:0]  pb_r  [NELEM];
  logic signed [15:0]       m2_r  [3];
  logic signed [15:0]       m3_r  [3];
  logic signed [CFW-1:0]    cf3_r [NELEM];
  logic signed [CFW-1:0]    cf4_r [NELEM];
  logic signed [CFW-1:0]    cf5_r [NELEM];
  logic signed [DETW-1:0]   dp_r  [3];
  logic signed [DETW-1:0]   det_r;
  divstg_t                  dv_r  [QBITS+1];
  divstg_t                  dv_nxt;
  logic [31:0]              vo_r_v [NELEM];
  logic [31:0]              vo_nxt [NELEM];
  logic                     sing_r, sat_r, sat_nxt;

  // hold everything while the result word waits
  assign en       = !vo_r || out_ready;
  assign in_ready = en;
  assign pready   = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRW'(1);
    end else if (psel && penable && pwrite && paddr[3] == REG_DET_THRESHOLD) begin
      thr_r <= pwdata[THRW-1:0];
    end
  end

  assign prdata = (paddr[3] == REG_DET_THRESHOLD) ? {{(64-THRW){1'b0}}, thr_r} : 64'd0;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0; v5_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      vo_r <= dv_r[QBITS].vld;
    end
  end

  // products, cofactors, determinant
  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0] <= in_e0; m_r[1] <= in_e1; m_r[2] <= in_e2;
      m_r[3] <= in_e3; m_r[4] <= in_e4; m_r[5] <= in_e5;
      m_r[6] <= in_e6; m_r[7] <= in_e7; m_r[8] <= in_e8;
      for (int k = 0; k < NELEM; k++) begin
        pa_r[k]  <= PRODW'(m_r[PA1[k]] * m_r[PA2[k]]);
        pb_r[k]  <= PRODW'(m_r[PB1[k]] * m_r[PB2[k]]);
        cf3_r[k] <= CFW'(pa_r[k]) - CFW'(pb_r[k]);
        cf4_r[k] <= cf3_r[k];
        cf5_r[k] <= cf4_r[k];
      end
      for (int k = 0; k < 3; k++) begin
        m2_r[k] <= m_r[k];
        m3_r[k] <= m2_r[k];
        dp_r[k] <= DETW'(m3_r[k]) * DETW'(cf3_r[k]);
      end
      det_r <= dp_r[0] + dp_r[1] + dp_r[2];
    end
  end

  // divider setup: singular flag, and magnitude, sign, overflow and first remainder per lane
  always_comb begin
    logic [DETW-1:0] t;
    logic [DENW-1:0] adet;
    logic [31:0]     mag;
    t    = det_r[DETW-1] ? DETW'(-det_r) : DETW'(det_r);
    adet = t[DENW-1:0];
    dv_nxt.vld  = v5_r;
    dv_nxt.sing = (adet == '0) || ({1'b0, adet} < thr_r);
    dv_nxt.den  = adet;
    for (int k = 0; k < NELEM; k++) begin
      mag = mag33(cf5_r[TPOS[k]]);
      dv_nxt.lane[k].rem = DENW'(mag[31:4]);
      dv_nxt.lane[k].nb  = mag[3:0];
      dv_nxt.lane[k].q   = '0;
      dv_nxt.lane[k].neg = cf5_r[TPOS[k]][CFW-1] ^ det_r[DETW-1];
      dv_nxt.lane[k].ovf = ({20'd0, mag} >= {adet, 4'd0});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0].vld <= 1'b0;
    end else if (en) begin
      dv_r[0] <= dv_nxt;
    end
  end

  for (genvar s = 1; s <= QBITS; s++) begin : g_div
    divstg_t st_nxt;
    always_comb begin
      st_nxt = dv_r[s-1];
      for (int k = 0; k < NELEM; k++) begin
        st_nxt.lane[k] = div_step(dv_r[s-1].lane[k], dv_r[s-1].den);
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[s].vld <= 1'b0;
      end else if (en) begin
        dv_r[s] <= st_nxt;
      end
    end
  end

  // sign, clamp and singular masking
  always_comb begin
    lane_t l;
    sat_nxt = 1'b0;
    for (int k = 0; k < NELEM; k++) begin
      l = dv_r[QBITS].lane[k];
      if (dv_r[QBITS].sing) begin
        vo_nxt[k] = '0;
      end else if (l.neg) begin
        if (l.ovf || l.q > 32'h8000_0000) begin
          vo_nxt[k] = 32'h8000_0000;
          sat_nxt   = 1'b1;
        end else begin
          vo_nxt[k] = 32'(-l.q);
        end
      end else begin
        if (l.ovf || l.q[31]) begin
          vo_nxt[k] = 32'h7FFF_FFFF;
          sat_nxt   = 1'b1;
        end else begin
          vo_nxt[k] = l.q;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vo_r_v <= vo_nxt;
      sing_r <= dv_r[QBITS].sing;
      sat_r  <= sat_nxt;
    end
  end

  assign out_valid     = vo_r;
  assign out_v0        = vo_r_v[0];
  assign out_v1        = vo_r_v[1];
  assign out_v2        = vo_r_v[2];
  assign out_v3        = vo_r_v[3];
  assign out_v4        = vo_r_v[4];
  assign out_v5        = vo_r_v[5];
  assign out_v6        = vo_r_v[6];
  assign out_v7        = vo_r_v[7];
  assign out_v8        = vo_r_v[8];
  assign out_singular  = sing_r;
  assign out_saturated = sat_r;

endmodule

// ===== tb/sv/tb_matrix3_inverse.sv =====
// ----------------------------------------------------------------------------
// tb_matrix3_inverse: self-checking bench for the 3x3 fixed-point inverse
// Drives Q4.12 matrices with bursty valid, stalls the result side, predicts
// each inverse word in Q16.16 with its singular and saturated flags, and
// compares every field. The singular threshold is swept across several values.
// ----------------------------------------------------------------------------
module tb_matrix3_inverse
  import m3inv_pkg::*;
();

  typedef struct {
    logic signed [15:0] e [9];
  } mat_t;

  typedef struct {
    logic signed [31:0] v [9];
    logic               sing;
    logic               sat;
  } inv_t;

  // one row of the directed table; has_exp marks an answer typed in by hand
  typedef struct {
    mat_t m;
    bit   has_exp;
    inv_t x;
  } vec_t;

  localparam int LIMIT_CYCLES = 1500000;
  localparam int DRAIN_CYCLES = 60;

  logic clk, rst_n;
  logic in_valid, in_ready;
  logic signed [15:0] in_e [9];
  logic out_valid, out_ready;
  logic signed [31:0] out_v [9];
  logic out_singular, out_saturated;
  logic psel, penable, pwrite;
  logic [3:0] paddr;
  logic [63:0] pwdata, prdata;
  logic pready;

  logic [THRW-1:0] det_thr;
  inv_t inv_q[$];
  int   n_err, n_words, n_sing, n_sat, cyc;
  bit   hold_long;

  matrix3_inverse dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_e0(in_e[0]), .in_e1(in_e[1]), .in_e2(in_e[2]),
    .in_e3(in_e[3]), .in_e4(in_e[4]), .in_e5(in_e[5]),
    .in_e6(in_e[6]), .in_e7(in_e[7]), .in_e8(in_e[8]),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_v0(out_v[0]), .out_v1(out_v[1]), .out_v2(out_v[2]),
    .out_v3(out_v[3]), .out_v4(out_v[4]), .out_v5(out_v[5]),
    .out_v6(out_v[6]), .out_v7(out_v[7]), .out_v8(out_v[8]),
    .out_singular(out_singular), .out_saturated(out_saturated),
    .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc >= LIMIT_CYCLES) begin
        $display("timeout after %0d cycles, %0d words pending", cyc, inv_q.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic inv_t calc_inverse(mat_t a, logic [THRW-1:0] thr);
    longint m [9];
    longint c [9];
    longint det, cf;
    longint unsigned adet, q;
    bit neg;
    inv_t r;
    for (int i = 0; i < 9; i++) m[i] = a.e[i];
    c[0] =   m[4]*m[8] - m[7]*m[5];
    c[1] = -(m[3]*m[8] - m[6]*m[5]);
    c[2] =   m[3]*m[7] - m[6]*m[4];
    c[3] = -(m[1]*m[8] - m[7]*m[2]);
    c[4] =   m[0]*m[8] - m[6]*m[2];
    c[5] = -(m[0]*m[7] - m[6]*m[1]);
    c[6] =   m[1]*m[5] - m[4]*m[2];
    c[7] = -(m[0]*m[5] - m[3]*m[2]);
    c[8] =   m[0]*m[4] - m[3]*m[1];
    det  = m[0]*c[0] + m[1]*c[1] + m[2]*c[2];
    adet = det < 0 ? -det : det;
    r.sat = 1'b0;
    r.sing = 1'b0;
    if (adet == 0 || adet < {15'd0, thr}) begin
      foreach (r.v[k]) r.v[k] = '0;
      r.sing = 1'b1;
      return r;
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        cf  = c[3*i+j];
        q   = ((cf < 0) ? -cf : cf) << 28;
        q   = q / adet;
        neg = (cf < 0) != (det < 0);
        if (neg && q > 64'h8000_0000) begin
          q = 64'h8000_0000;
          r.sat = 1'b1;
        end else if (!neg && q > 64'h7FFF_FFFF) begin
          q = 64'h7FFF_FFFF;
          r.sat = 1'b1;
        end
        r.v[3*j+i] = neg ? 32'(-q) : 32'(q);
      end
    return r;
  endfunction

  task automatic write_thr(logic [THRW-1:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= 4'd8 * 4'(REG_DET_THRESHOLD);
    pwdata  <= 64'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    det_thr = val;
  endtask

  task automatic wait_idle();
    while (inv_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  int burst_left, gap_left;

  // offer one word, with bursts and gaps in front of it
  task automatic send_matrix(mat_t a, bit has_exp, inv_t x);
    if (burst_left == 0) begin
      gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        repeat (gap_left) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    for (int i = 0; i < 9; i++) in_e[i] <= a.e[i];
    do @(posedge clk); while (!in_ready);
    inv_q.push_back(has_exp ? x : calc_inverse(a, det_thr));
  endtask

  function automatic mat_t rand_matrix(int mode);
    mat_t a;
    for (int i = 0; i < 9; i++) begin
      case (mode)
        0: a.e[i] = 16'($urandom);
        1: a.e[i] = 16'($signed($urandom_range(0, 16383)) - 8192);
        2: a.e[i] = 16'($signed($urandom_range(0, 255)) - 128);
        default: a.e[i] = (i % 4 == 0) ? 16'($urandom_range(2048, 32767))
                                       : 16'($signed($urandom_range(0, 511)) - 256);
      endcase
    end
    if (mode == 4) begin
      // make columns 0 and 2 equal so the determinant vanishes
      a.e[6] = a.e[0]; a.e[7] = a.e[1]; a.e[8] = a.e[2];
    end
    return a;
  endfunction

  function automatic mat_t diag(logic signed [15:0] d0, logic signed [15:0] d1,
                                logic signed [15:0] d2);
    mat_t a;
    foreach (a.e[i]) a.e[i] = '0;
    a.e[0] = d0; a.e[4] = d1; a.e[8] = d2;
    return a;
  endfunction

  // result side: stall pattern, plus one long hold-off
  initial begin
    int k;
    out_ready <= 1'b0;
    k = 0;
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_long = 1'b0;
      end
      k++;
      out_ready <= (k % 64 < 16) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    inv_t got, want;
    bit bad;
    n_err = 0; n_words = 0; n_sing = 0; n_sat = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        foreach (out_v[i]) got.v[i] = out_v[i];
        got.sing = out_singular;
        got.sat  = out_saturated;
        n_words++;
        if (inv_q.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected word at cycle %0d", cyc);
        end else begin
          want = inv_q.pop_front();
          bad = (got.sing !== want.sing) || (got.sat !== want.sat);
          foreach (want.v[i]) if (got.v[i] !== want.v[i]) bad = 1'b1;
          n_sing += want.sing;
          n_sat  += want.sat;
          if (bad) begin
            n_err++;
            if (n_err <= 10)
              $display("mismatch word %0d: exp v=%p sing=%0b sat=%0b got v=%p sing=%0b sat=%0b",
                       n_words, want.v, want.sing, want.sat, got.v, got.sing, got.sat);
          end
        end
      end
    end
  end

  initial begin
    vec_t dir [$];
    vec_t row;
    inv_t z, one;
    logic [THRW-1:0] thr_set [5];
    mat_t a;
    rst_n = 1'b0;
    in_valid = 1'b0;
    foreach (in_e[i]) in_e[i] = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    hold_long = 1'b0;
    burst_left = 0;
    det_thr = 1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (z.v[i]) z.v[i] = '0;
    z.sing = 1'b1; z.sat = 1'b0;
    one = z; one.sing = 1'b0;
    one.v[0] = 32'h0001_0000; one.v[4] = 32'h0001_0000; one.v[8] = 32'h0001_0000;

    // zero matrix: singular
    row.m = diag(0, 0, 0); row.has_exp = 1; row.x = z; dir.push_back(row);
    // identity in Q4.12 gives identity in Q16.16
    row.m = diag(16'sh1000, 16'sh1000, 16'sh1000); row.x = one; dir.push_back(row);
    // smallest nonzero diagonal: det 1, at reset threshold
    row.has_exp = 0;
    row.m = diag(1, 1, 1); dir.push_back(row);
    row.m = diag(-1, 1, 1); dir.push_back(row);
    row.m = diag(-32768, -32768, -32768); dir.push_back(row);
    row.m = diag(32767, 32767, 32767); dir.push_back(row);
    row.m = diag(-32768, 32767, -32768); dir.push_back(row);
    foreach (row.m.e[i]) row.m.e[i] = -32768; dir.push_back(row);
    foreach (row.m.e[i]) row.m.e[i] = 32767;  dir.push_back(row);
    for (int i = 0; i < 9; i++) begin
      row.m = diag(16'sh1000, 16'sh1000, 16'sh1000);
      row.m.e[i] = (i % 2) ? 16'sh7FFF : 16'sh8000;
      dir.push_back(row);
    end
    for (int i = 0; i < 5; i++) begin
      row.m = rand_matrix(i % 5); dir.push_back(row);
    end

    foreach (dir[i]) send_matrix(dir[i].m, dir[i].has_exp, dir[i].x);
    in_valid <= 1'b0;
    wait_idle();

    thr_set[0] = 0;
    thr_set[1] = 49'h1_0000_0000_0000;
    thr_set[2] = 49'h0_0010_0000_0000;
    thr_set[3] = 49'h0_0000_0100_0000;
    thr_set[4] = 49'h1;
    for (int p = 0; p < 5; p++) begin
      write_thr(thr_set[p]);
      if (p == 2) hold_long = 1'b1;
      for (int n = 0; n < 320; n++) begin
        a = rand_matrix($urandom_range(0, 4));
        if (p == 3 && $urandom_range(0, 7) == 0)
          a = diag(16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)),
                   16'($urandom_range(1, 8)));
        send_matrix(a, 0, z);
      end
      in_valid <= 1'b0;
      wait_idle();
    end

    $display("checked %0d inverse words over 6 threshold settings", n_words);
    $display("%0d singular, %0d saturated", n_sing, n_sat);
    if (n_err == 0 && inv_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d errors", n_err);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/m3inv_pkg.sv
sv/matrix3_inverse.sv
tb/sv/tb_matrix3_inverse.sv
